// ----- hdl/mps_pkg.sv -----
// shared types and constants of the motor pattern sequencer
// no dependencies; imported by every module of the block

package mps_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,
        OP_TICK = 2'd1,
        OP_STOP = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SWITCH_LIMIT = 2'd0,
        CFG_SHORT_PERIOD = 2'd1,
        CFG_LONG_PERIOD  = 2'd2
    } cfg_index_t;

    // pattern modes
    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_ALT    = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    localparam logic [15:0] SWITCH_LIMIT_RST = 16'd30000;
    localparam logic [15:0] SHORT_PERIOD_RST = 16'd500;
    localparam logic [15:0] LONG_PERIOD_RST  = 16'd1000;

    localparam logic [3:0]  FRAME_HOLD_FIRST = 4'd7;
    localparam logic [3:0]  FRAME_HOLD_LAST  = 4'd11;
    localparam logic [10:0] MS_PER_SECOND    = 11'd1000;
    localparam logic [15:0] SECONDS_MAX      = 16'd60000;
    localparam logic [2:0]  PHASE_LAST       = 3'd3;

    typedef struct packed {
        logic        frame;
        logic        switch_run;
        logic        step_run;
    } run_flags_t;

    // one result, packed as it leaves on m_tdata (lowest field last here)
    typedef struct packed {
        logic [15:0] auto_close_seconds;
        logic [1:0]  pattern_mode;
        logic        motor_b_pin;
        logic        motor_a_pin;
    } result_t;

endpackage

// ----- hdl/mps_core.sv -----
// pattern state and single-pass next-state logic of the motor pattern sequencer
// depends on mps_pkg

module mps_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               item_accept,
    input  mps_pkg::op_t       op,
    input  logic               auto_close_enable,
    output mps_pkg::result_t   result
);
    import mps_pkg::*;

    logic [15:0] switch_limit_reg, short_period_reg, long_period_reg;

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] step_timer_reg, step_timer_next;
    logic [15:0] switch_timer_reg, switch_timer_next;
    logic [3:0]  frame_count_reg, frame_count_next;
    logic [2:0]  mode1_phase_reg, mode1_phase_next;
    logic        mode2_toggle_reg, mode2_toggle_next;
    logic        mode3_toggle_reg, mode3_toggle_next;
    logic [1:0]  motor_wants_reg, motor_wants_next;
    run_flags_t  run_flags_reg, run_flags_next;
    logic [1:0]  pin_levels_reg, pin_levels_next;
    logic [10:0] ms_count_reg, ms_count_next;
    logic [15:0] seconds_count_reg, seconds_count_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_limit_reg <= SWITCH_LIMIT_RST;
            short_period_reg <= SHORT_PERIOD_RST;
            long_period_reg  <= LONG_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SWITCH_LIMIT: switch_limit_reg <= cfg_wdata;
                CFG_SHORT_PERIOD: short_period_reg <= cfg_wdata;
                CFG_LONG_PERIOD:  long_period_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic        overflow;
        logic [15:0] period;
        logic [2:0]  phase;
        logic [3:0]  frame;

        mode_next          = mode_reg;
        step_timer_next    = step_timer_reg;
        switch_timer_next  = switch_timer_reg;
        frame_count_next   = frame_count_reg;
        mode1_phase_next   = mode1_phase_reg;
        mode2_toggle_next  = mode2_toggle_reg;
        mode3_toggle_next  = mode3_toggle_reg;
        motor_wants_next   = motor_wants_reg;
        run_flags_next     = run_flags_reg;
        pin_levels_next    = pin_levels_reg;
        ms_count_next      = ms_count_reg;
        seconds_count_next = seconds_count_reg;
        overflow           = 1'b0;
        period             = short_period_reg;
        phase              = mode1_phase_reg;
        frame              = frame_count_reg;

        unique case (op)
            OP_PASS:
            begin
                run_flags_next.switch_run = 1'b1;
                run_flags_next.frame      = 1'b1;
                if (switch_timer_reg > switch_limit_reg)
                begin
                    switch_timer_next = '0;
                    step_timer_next   = '0;
                    // leaving the last mode wraps to the first without arming the step timer
                    if (mode_reg == MODE_TOGGLE)
                    begin
                        mode_next = MODE_STEP;
                        overflow  = 1'b1;
                    end
                    else
                    begin
                        mode_next = mode_reg + 2'd1;
                    end
                end
                if (!overflow)
                begin
                    run_flags_next.step_run = 1'b1;
                    period = (mode_next == MODE_ALT) ? long_period_reg : short_period_reg;
                    if (step_timer_next > period)
                    begin
                        step_timer_next = '0;
                        unique case (mode_next)
                            MODE_STEP:
                            begin
                                phase = (mode1_phase_reg > PHASE_LAST) ? 3'd1
                                                                       : mode1_phase_reg + 3'd1;
                                mode1_phase_next = phase;
                                unique case (phase)
                                    3'd1:    motor_wants_next = 2'b01;
                                    3'd2:    motor_wants_next = 2'b10;
                                    3'd3:    motor_wants_next = 2'b00;
                                    default: ;
                                endcase
                            end
                            MODE_ALT:
                            begin
                                mode2_toggle_next = ~mode2_toggle_reg;
                                motor_wants_next  = mode2_toggle_reg ? 2'b10 : 2'b01;
                            end
                            default:
                            begin
                                mode3_toggle_next = ~mode3_toggle_reg;
                                motor_wants_next  = mode3_toggle_reg ? 2'b00 : 2'b11;
                            end
                        endcase
                    end
                end
            end
            OP_TICK:
            begin
                if (run_flags_reg.step_run)
                    step_timer_next = step_timer_reg + 16'd1;
                if (run_flags_reg.switch_run)
                    switch_timer_next = switch_timer_reg + 16'd1;
                if (run_flags_reg.frame)
                begin
                    frame = frame_count_reg + 4'd1;
                    frame_count_next = frame;
                    // drive on counts 1-6, hold on 7-11, low and restart on 12
                    if (frame < FRAME_HOLD_FIRST)
                    begin
                        pin_levels_next = motor_wants_reg;
                    end
                    else if (frame > FRAME_HOLD_LAST)
                    begin
                        pin_levels_next  = '0;
                        frame_count_next = '0;
                    end
                end
                if (auto_close_enable)
                begin
                    if (ms_count_reg > MS_PER_SECOND)
                    begin
                        ms_count_next = '0;
                        if (seconds_count_reg < SECONDS_MAX)
                            seconds_count_next = seconds_count_reg + 16'd1;
                    end
                    else
                    begin
                        ms_count_next = ms_count_reg + 11'd1;
                    end
                end
                else
                begin
                    ms_count_next = '0;
                end
            end
            OP_STOP:
            begin
                mode_next               = MODE_STEP;
                frame_count_next        = '0;
                switch_timer_next       = '0;
                run_flags_next.frame    = 1'b0;
                pin_levels_next         = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_STEP;
            step_timer_reg    <= '0;
            switch_timer_reg  <= '0;
            frame_count_reg   <= '0;
            mode1_phase_reg   <= '0;
            mode2_toggle_reg  <= 1'b0;
            mode3_toggle_reg  <= 1'b0;
            motor_wants_reg   <= '0;
            run_flags_reg     <= '0;
            pin_levels_reg    <= '0;
            ms_count_reg      <= '0;
            seconds_count_reg <= '0;
        end
        else if (item_accept)
        begin
            mode_reg          <= mode_next;
            step_timer_reg    <= step_timer_next;
            switch_timer_reg  <= switch_timer_next;
            frame_count_reg   <= frame_count_next;
            mode1_phase_reg   <= mode1_phase_next;
            mode2_toggle_reg  <= mode2_toggle_next;
            mode3_toggle_reg  <= mode3_toggle_next;
            motor_wants_reg   <= motor_wants_next;
            run_flags_reg     <= run_flags_next;
            pin_levels_reg    <= pin_levels_next;
            ms_count_reg      <= ms_count_next;
            seconds_count_reg <= seconds_count_next;
        end
    end

    assign result.motor_a_pin        = pin_levels_next[0];
    assign result.motor_b_pin        = pin_levels_next[1];
    assign result.pattern_mode       = mode_next;
    assign result.auto_close_seconds = seconds_count_next;

endmodule

// ----- hdl/mps_out_skid.sv -----
// result register with a skid stage for the motor pattern sequencer
// depends on mps_pkg

module mps_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mps_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output mps_pkg::result_t out_data
);
    import mps_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg & out_ready;
    assign ready     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

endmodule

// ----- hdl/motor_pattern_sequencer.sv -----
// top level of the two-motor vibration pattern sequencer
// depends on mps_pkg, mps_core and mps_out_skid
// usage:
//   input stream (s_*): one operation per transaction, op in s_tuser
//   (pattern pass, 1 ms tick or stop), auto-close enable in s_tdata
//   output stream (m_*): exactly one result per input transaction, the pin
//   levels, pattern mode and auto-close seconds after that operation
//   config port: cfg_we writes cfg_wdata into the register picked by
//   cfg_index (0 switch limit, 1 short period, 2 long period); write only
//   while no transaction is in flight; unused indexes are ignored
// timing:
//   the whole update is one combinational pass off the state registers; a
//   result is registered in the output or skid stage as its input is taken,
//   and one item per cycle is taken while the output keeps draining
// reset:
//   rst_n clears all pattern state, the output and skid stages, and loads
//   the register defaults 30000 / 500 / 1000
// stalls:
//   with m_tready low the result register holds and one more result goes to
//   a skid stage; s_tready then drops until the held result is taken

module motor_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] auto_close_enable, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] motor_a_pin, [1] motor_b_pin,
                                   // [3:2] pattern_mode, [19:4] auto_close_seconds
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import mps_pkg::*;

    logic    item_accept;
    result_t core_result;
    result_t out_result;

    assign item_accept = s_tvalid & s_tready;

    mps_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .item_accept       (item_accept),
        .op                (op_t'(s_tuser)),
        .auto_close_enable (s_tdata[0]),
        .result            (core_result)
    );

    mps_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept),
        .push_data (core_result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {4'd0, out_result};

endmodule

// ----- hdl/mps_checker.sv -----
// port-level checks for the motor pattern sequencer, bound to the top level
// depends on mps_pkg

module mps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import mps_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input backpressure only while a result is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && $past(m_tvalid))
        else $error("input stalled with empty output");

    // the transient overflow mode never reaches the output
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:2] != 2'd3)
        else $error("pattern mode out of range");

    // seconds saturate
    a_seconds_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:4] <= SECONDS_MAX)
        else $error("seconds count above saturation");

endmodule

bind motor_pattern_sequencer mps_checker u_mps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/motor_pattern_sequencer_tb.sv -----
// self-checking testbench for motor_pattern_sequencer: pattern passes, ticks and stops
// on the input stream, every result checked against a cycle-free model of the sequencer
// depends on mps_pkg and the motor_pattern_sequencer rtl

`timescale 1ns / 100ps

module motor_pattern_sequencer_tb;
    import mps_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         IDLE_MAX     = 14;
    localparam int         HOLD_CYCLES  = 60;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 4;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // model copy of the registers and pattern state
    logic [15:0] lim_switch = SWITCH_LIMIT_RST;
    logic [15:0] per_short  = SHORT_PERIOD_RST;
    logic [15:0] per_long   = LONG_PERIOD_RST;
    logic [1:0]  mode_q     = MODE_STEP;
    logic [15:0] step_tmr   = '0;
    logic [15:0] switch_tmr = '0;
    logic [3:0]  frame_cnt  = '0;
    logic [2:0]  step_phase = '0;
    logic        alt_tgl    = 1'b0;
    logic        both_tgl   = 1'b0;
    logic [1:0]  wants      = '0;   // [0] motor a, [1] motor b
    run_flags_t  flags      = '0;
    logic [1:0]  pins       = '0;
    logic [10:0] ms_cnt     = '0;
    logic [15:0] seconds_q  = '0;

    result_t     expected_q[$];
    int          err_count    = 0;
    int          sent_count   = 0;
    int          result_count = 0;
    int          cfg_writes   = 0;
    int          idle_run     = 0;
    int          sink_wait    = 0;
    int          hold_ask     = 0;
    int          hold_seen    = 0;
    bit          quiet_src    = 1'b0;
    bit          quiet_sink   = 1'b0;

    motor_pattern_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // applies one operation to the model state and returns the expected result after it
    function automatic result_t drive_after(input logic [1:0] op, input logic en);
        result_t     r;
        logic [1:0]  prev_mode;
        logic [2:0]  prev_phase;
        logic [15:0] period;
        case (op)
            OP_PASS:
            begin
                flags.switch_run = 1'b1;
                flags.frame      = 1'b1;
                if (switch_tmr > lim_switch)
                begin
                    prev_mode  = mode_q;
                    switch_tmr = '0;
                    step_tmr   = '0;
                    mode_q     = mode_q + 2'd1;
                    if (prev_mode > MODE_TOGGLE)
                        mode_q = MODE_STEP;
                end
                if (mode_q > MODE_TOGGLE)
                begin
                    // overflow folds back without re-arming the step timer
                    mode_q = MODE_STEP;
                end
                else
                begin
                    flags.step_run = 1'b1;
                    period = (mode_q == MODE_ALT) ? per_long : per_short;
                    if (step_tmr > period)
                    begin
                        step_tmr = '0;
                        if (mode_q == MODE_STEP)
                        begin
                            prev_phase = step_phase;
                            step_phase = step_phase + 3'd1;
                            if (prev_phase > PHASE_LAST)
                                step_phase = 3'd1;
                            case (step_phase)
                                3'd1:    wants = 2'b01;
                                3'd2:    wants = 2'b10;
                                3'd3:    wants = 2'b00;
                                default: ;
                            endcase
                        end
                        else if (mode_q == MODE_ALT)
                        begin
                            alt_tgl = ~alt_tgl;
                            wants   = alt_tgl ? 2'b01 : 2'b10;
                        end
                        else
                        begin
                            both_tgl = ~both_tgl;
                            wants    = both_tgl ? 2'b11 : 2'b00;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (flags.step_run)
                    step_tmr = step_tmr + 16'd1;
                if (flags.switch_run)
                    switch_tmr = switch_tmr + 16'd1;
                if (flags.frame)
                begin
                    frame_cnt = frame_cnt + 4'd1;
                    if (frame_cnt < FRAME_HOLD_FIRST)
                        pins = wants;
                    else if (frame_cnt > FRAME_HOLD_LAST)
                    begin
                        pins      = '0;
                        frame_cnt = '0;
                    end
                end
                if (en)
                begin
                    // prescaler runs one past the limit before the second counts
                    if (ms_cnt > MS_PER_SECOND)
                    begin
                        ms_cnt = '0;
                        if (seconds_q < SECONDS_MAX)
                            seconds_q = seconds_q + 16'd1;
                    end
                    else
                        ms_cnt = ms_cnt + 11'd1;
                end
                else
                    ms_cnt = '0;
            end
            OP_STOP:
            begin
                mode_q     = MODE_STEP;
                frame_cnt  = '0;
                switch_tmr = '0;
                flags.frame = 1'b0;
                pins       = '0;
            end
            default: ;
        endcase
        r.motor_a_pin        = pins[0];
        r.motor_b_pin        = pins[1];
        r.pattern_mode       = mode_q;
        r.auto_close_seconds = seconds_q;
        return r;
    endfunction

    // called at a clock edge; returns at the edge where the transaction is taken
    task automatic send_op(input logic [1:0] op, input logic en);
        int unsigned gap;
        gap = quiet_src ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, en};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(drive_after(op, en));
        sent_count++;
    endtask

    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SWITCH_LIMIT: lim_switch = val;
            CFG_SHORT_PERIOD: per_short  = val;
            CFG_LONG_PERIOD:  per_long   = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(input logic [15:0] lim, input logic [15:0] sp,
                             input logic [15:0] lp);
        write_reg(CFG_SWITCH_LIMIT, lim);
        write_reg(CFG_SHORT_PERIOD, sp);
        write_reg(CFG_LONG_PERIOD, lp);
    endtask

    // mostly passes and ticks, with stops and the unused code mixed in
    task automatic send_random_op;
        int unsigned r;
        logic        en;
        r  = $urandom_range(0, 99);
        en = ($urandom_range(0, 9) != 0);
        if (r < 4)
            send_op(OP_STOP, en);
        else if (r < 8)
            send_op(OP_UNUSED, en);
        else if (r < 35)
            send_op(OP_PASS, en);
        else
            send_op(OP_TICK, en);
    endtask

    task automatic test_directed_cases;
        // nothing is armed before the first pass
        send_op(OP_UNUSED, 1'b1);
        send_op(OP_TICK, 1'b1);
        send_op(OP_STOP, 1'b1);
        write_all(16'd0, 16'd0, 16'd0);
        send_op(OP_PASS, 1'b0);
        // each tick pushes the switch timer past zero: modes step and overflow
        repeat (3)
        begin
            send_op(OP_TICK, 1'b0);
            send_op(OP_PASS, 1'b1);
        end
        write_reg(CFG_SWITCH_LIMIT, 16'hFFFF);
        // step pattern walks through all of its phases
        repeat (5)
        begin
            send_op(OP_TICK, 1'b1);
            send_op(OP_PASS, 1'b0);
        end
        send_op(OP_STOP, 1'b0);
        send_op(OP_UNUSED, 1'b0);
        send_op(OP_TICK, 1'b0);
    endtask

    task automatic test_random_patterns;
        logic [15:0] cfg_set[6][3];
        cfg_set[0] = '{16'd12, 16'd1, 16'd3};
        cfg_set[1] = '{16'd40, 16'd3, 16'd7};
        cfg_set[2] = '{16'd0, 16'd0, 16'd0};
        cfg_set[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        cfg_set[4] = '{16'd200, 16'd2, 16'hFFFF};
        cfg_set[5] = '{16'($urandom_range(0, 60)), 16'($urandom_range(0, 6)),
                       16'($urandom_range(0, 12))};
        for (int p = 0; p < 6; p++)
        begin
            write_all(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2]);
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink <= ($urandom_range(0, 3) == 0);
            repeat (80) send_random_op();
        end
        quiet_src  = 1'b0;
        quiet_sink <= 1'b0;
    endtask

    task automatic test_output_backpressure;
        write_all(16'd20, 16'd1, 16'd2);
        quiet_src = 1'b1;
        hold_ask <= hold_ask + 1;
        repeat (24) send_random_op();
        quiet_src = 1'b0;
    endtask

    task automatic test_auto_close_seconds;
        int ticks;
        ticks = 0;
        write_all(16'd50, 16'd4, 16'd9);
        quiet_src  = 1'b1;
        quiet_sink <= 1'b1;
        // a long run of enabled ticks walks the prescaler up, a disabled one clears it
        while (ticks < 180)
        begin
            if ($urandom_range(0, 4) == 0)
                send_op(($urandom_range(0, 7) == 0) ? OP_STOP : OP_PASS,
                        1'($urandom_range(0, 1)));
            else
            begin
                send_op(OP_TICK, 1'b1);
                ticks++;
            end
        end
        send_op(OP_TICK, 1'b0);
        quiet_src  = 1'b0;
        quiet_sink <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_patterns();
        test_output_backpressure();
        test_auto_close_seconds();
        wait_idle();
        $display("covered %0d transactions in, %0d results out, %0d register writes",
                 sent_count, result_count, cfg_writes);
        $display("ops pass/tick/stop/unused, mode overflow, frame gating, auto-close prescaler");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result sink: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            m_tready  <= 1'b0;
            sink_wait <= HOLD_CYCLES - 1;
        end
        else if (m_tready && m_tvalid)
        begin : next_stall
            int unsigned w;
            w = quiet_sink ? 0 : $urandom_range(0, IDLE_MAX);
            if (w == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready  <= 1'b0;
                sink_wait <= w - 1;
            end
        end
        else if (!m_tready)
        begin
            if (sink_wait == 0)
                m_tready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[19:0];
            result_count++;
            if (expected_q.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
            else
            begin
                want = expected_q.pop_front();
                if (got.motor_a_pin !== want.motor_a_pin)
                    flag_mismatch($sformatf("result %0d motor_a_pin got %b want %b",
                                            result_count, got.motor_a_pin, want.motor_a_pin));
                if (got.motor_b_pin !== want.motor_b_pin)
                    flag_mismatch($sformatf("result %0d motor_b_pin got %b want %b",
                                            result_count, got.motor_b_pin, want.motor_b_pin));
                if (got.pattern_mode !== want.pattern_mode)
                    flag_mismatch($sformatf("result %0d pattern_mode got %0d want %0d",
                                            result_count, got.pattern_mode, want.pattern_mode));
                if (got.auto_close_seconds !== want.auto_close_seconds)
                    flag_mismatch($sformatf("result %0d auto_close_seconds got %0d want %0d",
                                            result_count, got.auto_close_seconds,
                                            want.auto_close_seconds));
            end
        end
    end

    // cycles without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else if (idle_run == STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     STALL_LIMIT, expected_q.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

endmodule
